/* sv/lrc_pkg.sv */
// Shared types and operation codes for the LRU result cache.
// Used by the cache cell and by the top level; no dependencies.
package lrc_pkg;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] from_z;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic signed [31:0] to_z;
      logic               store_bit;
   } req_type;

   typedef struct packed {
      logic hit;
      logic answer_bit;
      logic evicted;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] from_z;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic signed [31:0] to_z;
   } key_type;

   typedef struct packed {
      key_type key;
      logic    ans;
      logic    valid;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctl_type;

endpackage

/* sv/lrc_cell.sv */
// One cache cell: a key, its answer bit and a valid flag, with a local key compare.
// Depends on lrc_pkg; the top level chains these cells in recency order.
module lrc_cell import lrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  key_type      cmp_key,
   input  entry_type    shift_in,
   output entry_type    entry_out,
   output logic         match_out
);

   logic    valid_ff;
   key_type key_ff;
   logic    ans_ff;
   logic    match_ff;
   logic    match_in;

   assign match_in = valid_ff && (key_ff == cmp_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
         if (ctl.clear) begin
            valid_ff <= 1'b0;
         end else if (ctl.load) begin
            valid_ff <= shift_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         key_ff <= shift_in.key;
         ans_ff <= shift_in.ans;
      end
   end

   assign entry_out = '{key: key_ff, ans: ans_ff, valid: valid_ff};
   assign match_out = match_ff;

endmodule

/* sv/lru_result_cache_top.sv */
// LRU result cache: a fully associative cache of key and answer-bit pairs in LRU order.
// Depends on lrc_pkg and lrc_cell.
//
// The cache is a row of ENTRIES cells kept in recency order, most recent at cell 0,
// with valid entries packed at the front. Each item goes through compare, encode and
// update: the key is compared in every cell at once and the match is registered, the
// single matching cell is encoded to an index, and then the row shifts by one cell from
// the front up to that index (or over its whole length for an insert miss, where the
// last cell falls off as the eviction). busy is high in the compare and encode steps,
// so a new item is taken only when idle or in the update step of the last one. The
// result strobe rsp_valid is high for one cycle, in the update step, and cannot be
// held off by the receiver. A clear acts in the update step; reset needs no clear pass.
module lru_result_cache_top import lrc_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_ENC, ST_UPD} state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               ans_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   key_type            cmp_key;
   entry_type          head;
   entry_type          cells [ENTRIES];
   cell_ctl_type       cell_ctl [ENTRIES];
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] ans_vec;
   logic [ENTRIES-1:0] valid_vec;
   logic               any_match;
   logic               any_ans;
   logic [IDX_W-1:0]   idx_enc;
   logic               is_lookup;
   logic               is_insert;
   logic               upd_clear;
   logic               upd_shift_hit;
   logic               upd_shift_all;
   rsp_type            rsp_in;

   assign busy   = (state_ff == ST_CMP) || (state_ff == ST_ENC);
   assign accept = start && !busy;

   assign is_lookup = (req_ff.mode == MODE_LOOKUP);
   assign is_insert = (req_ff.mode == MODE_INSERT);

   assign cmp_key = '{from_x: req_ff.from_x, from_y: req_ff.from_y, from_z: req_ff.from_z,
                      to_x: req_ff.to_x, to_y: req_ff.to_y, to_z: req_ff.to_z};

   // A hit reloads the front cell with the same key; the answer is the stored one
   // on a lookup and the new one on an insert.
   assign head = '{key: cmp_key, ans: (is_insert ? req_ff.store_bit : ans_ff), valid: 1'b1};

   assign upd_clear     = (state_ff == ST_UPD) && (req_ff.mode == MODE_CLEAR);
   assign upd_shift_hit = (state_ff == ST_UPD) && (is_lookup || is_insert) && hit_ff;
   assign upd_shift_all = (state_ff == ST_UPD) && is_insert && !hit_ff;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      entry_type shift_in;
      if (g == 0) begin : g_head
         assign shift_in = head;
      end else begin : g_link
         assign shift_in = cells[g-1];
      end

      assign cell_ctl[g] = '{load: upd_shift_all || (upd_shift_hit && (idx_ff >= IDX_W'(g))),
                             clear: upd_clear};

      lrc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl[g]),
         .cmp_key   (cmp_key),
         .shift_in  (shift_in),
         .entry_out (cells[g]),
         .match_out (match_vec[g])
      );

      assign ans_vec[g]   = cells[g].ans;
      assign valid_vec[g] = cells[g].valid;
   end

   // At most one cell matches, so OR-ing the positions gives its index.
   always_comb begin
      idx_enc = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) begin
            idx_enc = idx_enc | IDX_W'(i);
         end
      end
   end

   assign any_match = |match_vec;
   assign any_ans   = |(match_vec & ans_vec);

   always_comb begin
      rsp_in.hit        = any_match && (is_lookup || is_insert);
      rsp_in.answer_bit = any_match && is_lookup && any_ans;
      rsp_in.evicted    = is_insert && !any_match && valid_vec[ENTRIES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_ENC);
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_ENC;
            end
            ST_ENC: begin
               state_ff <= ST_UPD;
               rsp_ff   <= rsp_in;
            end
            ST_UPD: begin
               state_ff <= accept ? ST_CMP : ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_ENC) begin
         hit_ff <= any_match;
         idx_ff <= idx_enc;
         ans_ff <= any_ans;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell holds the same key");

   a_packed_valid: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + ENTRIES'(1))) == '0)
      else $error("valid entries are not packed at the front of the row");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> (!rsp_data.hit && !rsp_data.answer_bit))
      else $error("eviction reported together with a hit");
`endif

endmodule

/* test/lru_result_cache_top_tb.sv */
// Self-checking testbench for lru_result_cache_top: directed, eviction and random item traffic.
// Predicts every result with a recency-ordered list of its own; depends on lrc_pkg and the RTL.
module lru_result_cache_top_tb;
   import lrc_pkg::*;

   localparam int CACHE_DEPTH = 64;
   localparam int POOL_SIZE = 96;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      key_type key;
      logic    ans;
   } cached_answer_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Index 0 holds the most recent entry, the last index the least recent.
   cached_answer_type recency_list[$];
   rsp_type           expected_rsp_q[$];
   key_type           key_pool[POOL_SIZE];
   int                gap_percent;
   int                error_count;

   lru_result_cache_top #(.ENTRIES(CACHE_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type predict_cache(req_type item);
      rsp_type           r;
      cached_answer_type e;
      key_type           k;
      int                idx;
      r = '0;
      idx = -1;
      k.from_x = item.from_x;
      k.from_y = item.from_y;
      k.from_z = item.from_z;
      k.to_x = item.to_x;
      k.to_y = item.to_y;
      k.to_z = item.to_z;
      for (int i = 0; i < recency_list.size(); i++) begin
         if (idx < 0 && recency_list[i].key == k) idx = i;
      end
      case (item.mode)
         MODE_LOOKUP: begin
            if (idx >= 0) begin
               r.hit = 1'b1;
               r.answer_bit = recency_list[idx].ans;
               e = recency_list[idx];
               recency_list.delete(idx);
               recency_list.insert(0, e);
            end
         end
         MODE_INSERT: begin
            e.key = k;
            e.ans = item.store_bit;
            if (idx >= 0) begin
               r.hit = 1'b1;
               recency_list.delete(idx);
            end else if (recency_list.size() >= CACHE_DEPTH) begin
               recency_list.delete(recency_list.size() - 1);
               r.evicted = 1'b1;
            end
            recency_list.insert(0, e);
         end
         MODE_CLEAR: begin
            recency_list.delete();
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic key_type random_key();
      key_type k;
      k.from_x = $urandom;
      k.from_y = $urandom;
      k.from_z = $urandom;
      k.to_x = $urandom;
      k.to_y = $urandom;
      k.to_z = $urandom;
      return k;
   endfunction

   function automatic req_type make_item(logic [1:0] mode, key_type k, logic store_bit);
      req_type item;
      item.mode = mode;
      item.from_x = k.from_x;
      item.from_y = k.from_y;
      item.from_z = k.from_z;
      item.to_x = k.to_x;
      item.to_y = k.to_y;
      item.to_z = k.to_z;
      item.store_bit = store_bit;
      return item;
   endfunction

   // Mostly keys that are already known, so that hits and refreshes are common,
   // plus near misses one bit away and fresh keys that force allocation.
   function automatic key_type pick_key();
      key_type k;
      int      roll;
      roll = $urandom_range(99);
      if (roll < 65) begin
         k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (roll < 75) begin
         k = key_pool[$urandom_range(POOL_SIZE - 1)];
         k = k ^ (192'(1) << $urandom_range(191));
      end else begin
         k = random_key();
      end
      return k;
   endfunction

   function automatic logic [1:0] pick_mode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 1) return MODE_CLEAR;
      if (roll < 3) return MODE_UNUSED;
      if (roll < 48) return MODE_LOOKUP;
      return MODE_INSERT;
   endfunction

   // Drives one item and holds it until the block takes it; the expected result
   // is worked out at the edge that accepts the item.
   task automatic issue_item(req_type item);
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      expected_rsp_q = {expected_rsp_q, predict_cache(item)};
   endtask

   task automatic idle_for(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic maybe_idle();
      if ($urandom_range(99) < gap_percent) idle_for($urandom_range(15, 1));
   endtask

   task automatic test_directed_cases();
      key_type key_min;
      key_type key_max;
      key_type key_zero;
      key_type key_ones;
      key_type near_min;
      key_min = {6{32'h8000_0000}};
      key_max = {6{32'h7fff_ffff}};
      key_zero = '0;
      key_ones = '1;
      near_min = key_min;
      near_min.to_z = 32'h7fff_ffff;
      issue_item(make_item(MODE_LOOKUP, key_min, 1'b0));
      issue_item(make_item(MODE_INSERT, key_min, 1'b1));
      issue_item(make_item(MODE_LOOKUP, key_min, 1'b0));
      issue_item(make_item(MODE_INSERT, key_max, 1'b0));
      issue_item(make_item(MODE_LOOKUP, key_max, 1'b1));
      // Writing a key that is already present must overwrite, not duplicate.
      issue_item(make_item(MODE_INSERT, key_min, 1'b0));
      issue_item(make_item(MODE_LOOKUP, key_min, 1'b1));
      issue_item(make_item(MODE_LOOKUP, near_min, 1'b0));
      issue_item(make_item(MODE_INSERT, key_zero, 1'b1));
      issue_item(make_item(MODE_INSERT, key_ones, 1'b1));
      issue_item(make_item(MODE_UNUSED, key_min, 1'b1));
      issue_item(make_item(MODE_LOOKUP, key_ones, 1'b0));
      issue_item(make_item(MODE_LOOKUP, key_zero, 1'b1));
      issue_item(make_item(MODE_CLEAR, key_ones, 1'b1));
      issue_item(make_item(MODE_LOOKUP, key_min, 1'b0));
      issue_item(make_item(MODE_LOOKUP, key_zero, 1'b0));
      issue_item(make_item(MODE_INSERT, key_zero, 1'b1));
      issue_item(make_item(MODE_LOOKUP, key_zero, 1'b0));
      issue_item(make_item(MODE_CLEAR, key_zero, 1'b0));
   endtask

   // Fills the cache, refreshes the oldest entry and checks that the next
   // oldest is the one displaced.
   task automatic test_lru_eviction();
      key_type fill_keys[CACHE_DEPTH];
      issue_item(make_item(MODE_CLEAR, random_key(), 1'b0));
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         fill_keys[i] = random_key();
         issue_item(make_item(MODE_INSERT, fill_keys[i], 1'($urandom)));
         if (i % 8 == 3) idle_for($urandom_range(15, 1));
      end
      issue_item(make_item(MODE_LOOKUP, fill_keys[0], 1'b0));
      issue_item(make_item(MODE_INSERT, random_key(), 1'b1));
      issue_item(make_item(MODE_LOOKUP, fill_keys[1], 1'b0));
      issue_item(make_item(MODE_LOOKUP, fill_keys[0], 1'b0));
      issue_item(make_item(MODE_INSERT, fill_keys[5], 1'b1));
      issue_item(make_item(MODE_INSERT, random_key(), 1'b0));
      issue_item(make_item(MODE_LOOKUP, fill_keys[2], 1'b0));
      issue_item(make_item(MODE_LOOKUP, fill_keys[5], 1'b0));
   endtask

   task automatic test_random_traffic(int count);
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(2))
               0: gap_percent = 0;
               1: gap_percent = 20;
               default: gap_percent = 50;
            endcase
         end
         issue_item(make_item(pick_mode(), pick_key(), 1'($urandom)));
         maybe_idle();
      end
   endtask

   task automatic test_back_to_back(int count);
      for (int n = 0; n < count; n++) begin
         issue_item(make_item(pick_mode(), pick_key(), 1'($urandom)));
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: result arrived with nothing expected, actual %b",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $display("%0t: hit expected %b actual %b", $time, want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.answer_bit !== want.answer_bit) begin
               $display("%0t: answer_bit expected %b actual %b",
                        $time, want.answer_bit, rsp_data.answer_bit);
               error_count++;
            end
            if (rsp_data.evicted !== want.evicted) begin
               $display("%0t: evicted expected %b actual %b",
                        $time, want.evicted, rsp_data.evicted);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(12 * 400_000);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int drain_cycles;
      error_count = 0;
      gap_percent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_lru_eviction();
      test_random_traffic(720);
      test_back_to_back(100);

      @(negedge clock);
      start <= 1'b0;
      drain_cycles = 0;
      while (expected_rsp_q.size() != 0 && drain_cycles < 100) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (6) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_rsp_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* lru_result_cache_top.f */
sv/lrc_pkg.sv
sv/lrc_cell.sv
sv/lru_result_cache_top.sv
test/lru_result_cache_top_tb.sv
